FILE: design/psp_pkg.sv
// ----------------------------------------------------------------------------
// psp_pkg
// Shared types, codes and reset values of the periodic sensor poller.
// ----------------------------------------------------------------------------
package psp_pkg;

  // default counter width
  localparam int TIMER_BITS_DEF = 16;

  // field widths
  localparam int ACTION_W = 2;
  localparam int WORD_W   = 16;
  localparam int PTR_W    = 8;
  localparam int CMD_W    = 2;
  localparam int PHASE_W  = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // packed channel widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 72;

  // input actions
  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WR_DONE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RD_DONE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_BUS_ERR = 2'd3;

  // bus commands
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_PTR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RD_TWO = 2'd2;

  // sequencer phases
  localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
  localparam logic [PHASE_W-1:0] PH_TEMP_REQ = 4'd1;
  localparam logic [PHASE_W-1:0] PH_ID_REQ   = 4'd5;
  localparam logic [PHASE_W-1:0] PH_CFG_REQ  = 4'd9;
  localparam logic [PHASE_W-1:0] PH_ERROR    = 4'd13;

  // step within one register read
  localparam logic [1:0] SUB_WR_REQ  = 2'd0;
  localparam logic [1:0] SUB_WR_WAIT = 2'd1;
  localparam logic [1:0] SUB_RD_REQ  = 2'd2;
  localparam logic [1:0] SUB_RD_WAIT = 2'd3;

  // register group being read
  localparam logic [1:0] GRP_TEMP = 2'd0;
  localparam logic [1:0] GRP_ID   = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_READ_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_PTR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ID_PTR      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CFG_PTR     = 3'd6;

  // configuration reset values
  localparam logic [WORD_W-1:0] RST_READ_PERIOD = 16'd100;
  localparam logic [WORD_W-1:0] RST_TIMEOUT     = 16'd10;
  localparam logic [WORD_W-1:0] RST_GAP         = 16'd2;
  localparam logic [WORD_W-1:0] RST_BACKOFF     = 16'd100;
  localparam logic [PTR_W-1:0]  RST_TEMP_PTR    = 8'd0;
  localparam logic [PTR_W-1:0]  RST_ID_PTR      = 8'd15;
  localparam logic [PTR_W-1:0]  RST_CFG_PTR     = 8'd1;

  // configuration set
  typedef struct packed {
    logic [WORD_W-1:0] read_period_ticks;
    logic [WORD_W-1:0] timeout_ticks;
    logic [WORD_W-1:0] gap_ticks;
    logic [WORD_W-1:0] error_backoff_ticks;
    logic [PTR_W-1:0]  temp_pointer;
    logic [PTR_W-1:0]  id_pointer;
    logic [PTR_W-1:0]  config_pointer;
  } cfg_t;

  // one input item
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [WORD_W-1:0]   rx_word;
    logic                bus_taken_by_other;
    logic                start_refused;
  } item_t;

  // one result item
  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic [PTR_W-1:0]          register_pointer;
    logic signed [WORD_W-1:0]  temperature_raw;
    logic [WORD_W-1:0]         device_id;
    logic [WORD_W-1:0]         config_word;
    logic                      valid_res;
    logic                      new_data;
    logic [PHASE_W-1:0]        phase;
    logic                      bus_owned;
  } res_t;

endpackage

FILE: design/psp_cfg.sv
// ----------------------------------------------------------------------------
// psp_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module psp_cfg
  import psp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg_o
);

  cfg_t cfg_r;

  // register writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.read_period_ticks   <= RST_READ_PERIOD;
      cfg_r.timeout_ticks       <= RST_TIMEOUT;
      cfg_r.gap_ticks           <= RST_GAP;
      cfg_r.error_backoff_ticks <= RST_BACKOFF;
      cfg_r.temp_pointer        <= RST_TEMP_PTR;
      cfg_r.id_pointer          <= RST_ID_PTR;
      cfg_r.config_pointer      <= RST_CFG_PTR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_READ_PERIOD: cfg_r.read_period_ticks   <= cfg_wdata[WORD_W-1:0];
        REG_TIMEOUT:     cfg_r.timeout_ticks       <= cfg_wdata[WORD_W-1:0];
        REG_GAP:         cfg_r.gap_ticks           <= cfg_wdata[WORD_W-1:0];
        REG_BACKOFF:     cfg_r.error_backoff_ticks <= cfg_wdata[WORD_W-1:0];
        REG_TEMP_PTR:    cfg_r.temp_pointer        <= cfg_wdata[PTR_W-1:0];
        REG_ID_PTR:      cfg_r.id_pointer          <= cfg_wdata[PTR_W-1:0];
        REG_CFG_PTR:     cfg_r.config_pointer      <= cfg_wdata[PTR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

FILE: design/psp_core.sv
// ----------------------------------------------------------------------------
// psp_core
// Poller state and its single-step update: one item in, one result out.
// ----------------------------------------------------------------------------
module psp_core
  import psp_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step_en,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  // compare width covering both counters and 16-bit settings
  localparam int CW = (TIMER_BITS > WORD_W) ? TIMER_BITS : WORD_W;

  logic [PHASE_W-1:0]    phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] pause_r, pause_nxt;
  logic [TIMER_BITS-1:0] tmo_r, tmo_nxt;
  logic [TIMER_BITS-1:0] period_r, period_nxt;
  logic                  wdone_r, wdone_nxt;
  logic                  rdone_r, rdone_nxt;
  logic [WORD_W-1:0]     rxw_r, rxw_nxt;
  logic [WORD_W-1:0]     temp_r, temp_nxt;
  logic [WORD_W-1:0]     id_r, id_nxt;
  logic [WORD_W-1:0]     cfgw_r, cfgw_nxt;
  logic                  valid_r, valid_nxt;
  logic                  owner_r, owner_nxt;

  logic [PHASE_W-1:0]    phase_m1;
  logic [1:0]            grp;
  logic [1:0]            sub;
  logic [PTR_W-1:0]      grp_ptr;
  logic [TIMER_BITS-1:0] tmo_inc;
  logic                  tmo_hit;
  logic [CMD_W-1:0]      cmd;
  logic [PTR_W-1:0]      ptr;
  logic                  fresh;

  // decode the phase into register group and step
  assign phase_m1 = phase_r - 4'd1;
  assign grp      = phase_m1[3:2];
  assign sub      = phase_m1[1:0];
  assign grp_ptr  = (grp == GRP_TEMP) ? cfg.temp_pointer :
                    (grp == GRP_ID)   ? cfg.id_pointer : cfg.config_pointer;

  // completion timeout count
  assign tmo_inc = tmo_r + 1'b1;
  assign tmo_hit = CW'(tmo_inc) >= CW'(cfg.timeout_ticks);

  // next state for one item
  always_comb begin
    phase_nxt  = phase_r;
    pause_nxt  = pause_r;
    tmo_nxt    = tmo_r;
    period_nxt = period_r;
    wdone_nxt  = wdone_r;
    rdone_nxt  = rdone_r;
    rxw_nxt    = rxw_r;
    temp_nxt   = temp_r;
    id_nxt     = id_r;
    cfgw_nxt   = cfgw_r;
    valid_nxt  = valid_r;
    owner_nxt  = owner_r;
    cmd        = CMD_NONE;
    ptr        = '0;
    fresh      = 1'b0;
    unique case (item.action)
      ACT_WR_DONE: begin
        owner_nxt = 1'b0;
        wdone_nxt = 1'b1;
      end
      ACT_RD_DONE: begin
        owner_nxt = 1'b0;
        rdone_nxt = 1'b1;
        rxw_nxt   = item.rx_word;
      end
      ACT_BUS_ERR: begin
        owner_nxt = 1'b0;
        phase_nxt = PH_ERROR;
      end
      default: begin
        // task tick
        if (period_r != {TIMER_BITS{1'b1}}) period_nxt = period_r + 1'b1;
        priority if (pause_r != '0) begin
          pause_nxt = pause_r - 1'b1;
        end else if (phase_r == PH_IDLE) begin
          if (CW'(period_nxt) >= CW'(cfg.read_period_ticks)) begin
            period_nxt = '0;
            phase_nxt  = PH_TEMP_REQ;
          end
        end else if (phase_r < PH_ERROR) begin
          unique case (sub)
            SUB_WR_REQ, SUB_RD_REQ: begin
              // request a transfer unless another master holds the bus
              if (!(item.bus_taken_by_other && !owner_r)) begin
                owner_nxt = 1'b1;
                wdone_nxt = 1'b0;
                rdone_nxt = 1'b0;
                cmd = (sub == SUB_WR_REQ) ? CMD_WR_PTR : CMD_RD_TWO;
                ptr = (sub == SUB_WR_REQ) ? grp_ptr : '0;
                if (item.start_refused) begin
                  owner_nxt = 1'b0;
                  phase_nxt = PH_ERROR;
                end else begin
                  tmo_nxt   = '0;
                  phase_nxt = phase_r + 4'd1;
                end
              end
            end
            SUB_WR_WAIT: begin
              if (wdone_r) begin
                wdone_nxt = 1'b0;
                tmo_nxt   = '0;
                phase_nxt = phase_r + 4'd1;
                pause_nxt = TIMER_BITS'(CW'(cfg.gap_ticks));
              end else if (tmo_hit) begin
                tmo_nxt   = '0;
                owner_nxt = 1'b0;
                phase_nxt = PH_ERROR;
              end else begin
                tmo_nxt = tmo_inc;
              end
            end
            default: begin
              // waiting for read data
              if (rdone_r) begin
                rdone_nxt = 1'b0;
                tmo_nxt   = '0;
                if (grp == GRP_TEMP) begin
                  temp_nxt  = rxw_r;
                  valid_nxt = 1'b1;
                  fresh     = 1'b1;
                  phase_nxt = PH_ID_REQ;
                end else if (grp == GRP_ID) begin
                  id_nxt    = rxw_r;
                  phase_nxt = PH_CFG_REQ;
                end else begin
                  cfgw_nxt  = rxw_r;
                  phase_nxt = PH_IDLE;
                end
              end else if (tmo_hit) begin
                tmo_nxt   = '0;
                owner_nxt = 1'b0;
                phase_nxt = PH_ERROR;
              end else begin
                tmo_nxt = tmo_inc;
              end
            end
          endcase
        end else if (phase_r == PH_ERROR) begin
          pause_nxt = TIMER_BITS'(CW'(cfg.error_backoff_ticks));
          phase_nxt = PH_TEMP_REQ;
        end else begin
          // unused phase codes
          phase_nxt = PH_ERROR;
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pause_r  <= '0;
      tmo_r    <= '0;
      period_r <= '0;
      wdone_r  <= 1'b0;
      rdone_r  <= 1'b0;
      rxw_r    <= '0;
      temp_r   <= '0;
      id_r     <= '0;
      cfgw_r   <= '0;
      valid_r  <= 1'b0;
      owner_r  <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      pause_r  <= pause_nxt;
      tmo_r    <= tmo_nxt;
      period_r <= period_nxt;
      wdone_r  <= wdone_nxt;
      rdone_r  <= rdone_nxt;
      rxw_r    <= rxw_nxt;
      temp_r   <= temp_nxt;
      id_r     <= id_nxt;
      cfgw_r   <= cfgw_nxt;
      valid_r  <= valid_nxt;
      owner_r  <= owner_nxt;
    end
  end

  // result of this step, read after the update
  always_comb begin
    res.command          = cmd;
    res.register_pointer = ptr;
    res.temperature_raw  = temp_nxt;
    res.device_id        = id_nxt;
    res.config_word      = cfgw_nxt;
    res.valid_res        = valid_nxt;
    res.new_data         = fresh;
    res.phase            = phase_nxt;
    res.bus_owned        = owner_nxt;
  end

endmodule

FILE: design/periodic_i2c_sensor_poller.sv
// ----------------------------------------------------------------------------
// periodic_i2c_sensor_poller
// Sequencer that polls a temperature sensor on a shared two-wire bus.
// ----------------------------------------------------------------------------
// Each accepted event (task tick, pointer write done, read done, bus error)
// yields exactly one result carrying the bus command to issue and the latest
// temperature, id and configuration readings. The block takes one event per
// clock cycle while the result register is free or being read; the event is
// captured in the input register, and a step moves it through the step logic
// into the result register once that register frees up. Each step is one
// state update in psp_core.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata.
// ----------------------------------------------------------------------------
module periodic_i2c_sensor_poller
  import psp_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // event input
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // rx_word, bus_taken_by_other, start_refused
  input  logic [ACTION_W-1:0]   in_tuser,   // action
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // command, register_pointer, temperature_raw, device_id, config_word,
  // valid_res, new_data, phase, bus_owned
  output logic [OUT_DATA_W-1:0] out_tdata,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic  in_v_r;
  item_t in_r;
  logic  out_v_r;
  res_t  out_r;
  logic  step;
  cfg_t  cfg;
  res_t  res;

  // step when an item is held and the result slot frees up
  assign step      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || step;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_r.action             <= in_tuser;
      in_r.rx_word            <= in_tdata[15:0];
      in_r.bus_taken_by_other <= in_tdata[16];
      in_r.start_refused      <= in_tdata[17];
    end
  end

  psp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  psp_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .item    (in_r),
    .cfg     (cfg),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  // pack the result
  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0,
                       out_r.bus_owned,
                       out_r.phase,
                       out_r.new_data,
                       out_r.valid_res,
                       out_r.config_word,
                       out_r.device_id,
                       out_r.temperature_raw,
                       out_r.register_pointer,
                       out_r.command};

endmodule
